// ----- rtl/prewitt_edge_magnitude_rgb_core_defines.svh -----
// Assertion macros shared by the edge magnitude core
`ifndef PREWITT_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
`define PREWITT_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PEMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PEMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pemr_pkg.sv -----
// Shared constants and controller/datapath types for the edge magnitude core
package pemr_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int RING_ROWS  = 4;
  localparam int RING_W     = $clog2(RING_ROWS);
  localparam int ADDR_W     = RING_W + COL_W;
  localparam int RAM_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int CFG_W      = 11;
  localparam int POS_W      = 11;
  localparam int PIX_W      = 24;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 22;
  localparam int REM_W      = 14;
  localparam int ROOT_W     = 11;
  localparam int SQRT_STEPS = 11;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PIX_MAX    = 255;

  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [0:0] KIND_PIXEL = 1'b0;
  localparam logic [0:0] KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        cell_row;
    logic [1:0]        cell_col;
    logic              clr;
    logic              sq;
    logic              root_step;
    logic              load;
    logic              frame_end;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;
endpackage

// ----- rtl/pemr_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module pemr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/pemr_ctrl.sv -----
// Controller: frame positions, config registers, window read sequencing and math schedule
`include "prewitt_edge_magnitude_rgb_core_defines.svh"
module pemr_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tuser,
  output logic                               in_tready,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [pemr_pkg::CFG_W-1:0]         cfg_wdata,
  input  pemr_pkg::sts_t                     sts,
  output pemr_pkg::cmd_t                     cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [pemr_pkg::CFG_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [pemr_pkg::POS_W-1:0] in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [pemr_pkg::POS_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [1:0] ri_r, ri_nxt, ci_r, ci_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [pemr_pkg::RING_W-1:0] rs_r [3];
  logic [pemr_pkg::RING_W-1:0] rs_nxt [3];
  logic [pemr_pkg::COL_W-1:0] cs_r [3];
  logic [pemr_pkg::COL_W-1:0] cs_nxt [3];
  logic fe_r, fe_nxt;

  logic [pemr_pkg::POS_W-1:0] w_eff, h_eff;
  logic in_acc, restart, pix_ready, emit;
  logic [pemr_pkg::POS_W-1:0] r_cur, c_cur, e_row, e_col, e_col_inc, e_row_inc, c_inc;
  logic [pemr_pkg::RING_W-1:0] rd_row;
  logic [pemr_pkg::COL_W-1:0] rd_col;

  assign w_eff = (w_r == '0) ? pemr_pkg::POS_W'(1) :
                 (w_r > pemr_pkg::CFG_W'(pemr_pkg::MAX_WIDTH)) ?
                 pemr_pkg::POS_W'(pemr_pkg::MAX_WIDTH) : w_r;
  assign h_eff = (h_r == '0) ? pemr_pkg::POS_W'(1) :
                 (h_r > pemr_pkg::CFG_W'(pemr_pkg::MAX_HEIGHT)) ?
                 pemr_pkg::POS_W'(pemr_pkg::MAX_HEIGHT) : h_r;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign restart   = (in_row_r >= h_eff) || (in_col_r >= w_eff) ||
                     (out_row_r >= h_eff) || (out_col_r >= w_eff);
  assign r_cur     = restart ? '0 : in_row_r;
  assign c_cur     = restart ? '0 : in_col_r;
  assign c_inc     = c_cur + pemr_pkg::POS_W'(1);
  assign pix_ready = (r_cur >= pemr_pkg::POS_W'(2)) ||
                     ((r_cur == pemr_pkg::POS_W'(1)) && (c_cur >= pemr_pkg::POS_W'(1)));
  assign e_row     = (in_tuser == pemr_pkg::KIND_PIXEL && restart) ? '0 : out_row_r;
  assign e_col     = (in_tuser == pemr_pkg::KIND_PIXEL && restart) ? '0 : out_col_r;
  assign e_row_inc = e_row + pemr_pkg::POS_W'(1);
  assign e_col_inc = e_col + pemr_pkg::POS_W'(1);

  always_comb begin
    unique case (ri_r)
      2'd0:    rd_row = rs_r[0];
      2'd1:    rd_row = rs_r[1];
      default: rd_row = rs_r[2];
    endcase
    unique case (ci_r)
      2'd0:    rd_col = cs_r[0];
      2'd1:    rd_col = cs_r[1];
      default: rd_col = cs_r[2];
    endcase
  end

  always_comb begin
    st_nxt      = st_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    ri_nxt      = ri_r;
    ci_nxt      = ci_r;
    cnt_nxt     = cnt_r;
    rs_nxt      = rs_r;
    cs_nxt      = cs_r;
    fe_nxt      = fe_r;
    emit        = 1'b0;
    cmd         = '0;
    cmd.rd_addr   = {rd_row, rd_col};
    cmd.cell_row  = ri_r;
    cmd.cell_col  = ci_r;
    cmd.frame_end = fe_r;
    cmd.wr_addr   = {r_cur[pemr_pkg::RING_W-1:0], c_cur[pemr_pkg::COL_W-1:0]};
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == pemr_pkg::KIND_DRAIN) begin
            emit = (in_row_r >= h_eff) && (out_row_r < h_eff);
          end else begin
            cmd.wr_en = 1'b1;
            out_col_nxt = e_col;
            out_row_nxt = e_row;
            if (c_inc >= w_eff) begin
              in_col_nxt = '0;
              in_row_nxt = r_cur + pemr_pkg::POS_W'(1);
            end else begin
              in_col_nxt = c_inc;
              in_row_nxt = r_cur;
            end
            emit = pix_ready;
          end
        end
        if (emit) begin
          rs_nxt[0] = (e_row == '0) ? '0 : pemr_pkg::RING_W'(e_row - pemr_pkg::POS_W'(1));
          rs_nxt[1] = e_row[pemr_pkg::RING_W-1:0];
          rs_nxt[2] = (e_row_inc >= h_eff) ?
                      pemr_pkg::RING_W'(h_eff - pemr_pkg::POS_W'(1)) :
                      e_row_inc[pemr_pkg::RING_W-1:0];
          cs_nxt[0] = (e_col == '0) ? '0 : pemr_pkg::COL_W'(e_col - pemr_pkg::POS_W'(1));
          cs_nxt[1] = e_col[pemr_pkg::COL_W-1:0];
          cs_nxt[2] = (e_col_inc >= w_eff) ?
                      pemr_pkg::COL_W'(w_eff - pemr_pkg::POS_W'(1)) :
                      e_col_inc[pemr_pkg::COL_W-1:0];
          fe_nxt = (e_row == h_eff - pemr_pkg::POS_W'(1)) &&
                   (e_col == w_eff - pemr_pkg::POS_W'(1));
          if (e_col_inc >= w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = e_row_inc;
          end else begin
            out_col_nxt = e_col_inc;
            out_row_nxt = e_row;
          end
          cmd.clr = 1'b1;
          ri_nxt  = '0;
          ci_nxt  = '0;
          st_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (ci_r == 2'd2) begin
          ci_nxt = '0;
          ri_nxt = ri_r + 2'd1;
          if (ri_r == 2'd2) begin
            st_nxt = S_LAST;
          end
        end else begin
          ci_nxt = ci_r + 2'd1;
        end
      end
      S_LAST: begin
        st_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        cnt_nxt = '0;
        st_nxt  = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(pemr_pkg::SQRT_STEPS - 1)) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      if (cfg_index == pemr_pkg::CFG_IMAGE_WIDTH) begin
        w_nxt = cfg_wdata;
      end else begin
        h_nxt = cfg_wdata;
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      w_r       <= pemr_pkg::CFG_W'(640);
      h_r       <= pemr_pkg::CFG_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      ri_r      <= '0;
      ci_r      <= '0;
      cnt_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      ri_r      <= ri_nxt;
      ci_r      <= ci_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt;
    cs_r <= cs_nxt;
    fe_r <= fe_nxt;
  end

  `PEMR_ASSERT_NOW(a_wr_only_idle, cmd.wr_en, st_r == S_IDLE, "pixel write outside idle")
  `PEMR_ASSERT_NOW(a_rd_only_read, cmd.rd_en, st_r == S_READ, "window read outside read phase")
  `PEMR_ASSERT_NEXT(a_read_to_last, st_r == S_READ && ri_r == 2'd2 && ci_r == 2'd2, st_r == S_LAST, "window read did not end after nine cells")
  `PEMR_ASSERT_NEXT(a_load_to_idle, cmd.load, st_r == S_IDLE && in_tready, "controller not idle after result load")
  `PEMR_ASSERT_NOW(a_load_free, cmd.load, !sts.out_busy, "result loaded over a pending item")
endmodule

// ----- rtl/pemr_dp.sv -----
// Datapath: row ring RAM, gradient accumulators, squares, bit-serial square root, output register
module pemr_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pemr_pkg::cmd_t              cmd,
  output pemr_pkg::sts_t              sts,
  input  logic [pemr_pkg::PIX_W-1:0]  pix_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pemr_pkg::PIX_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  logic [pemr_pkg::PIX_W-1:0] rd_data;
  logic rd_v_r;
  logic [1:0] crow_r, ccol_r;
  logic signed [pemr_pkg::GRAD_W-1:0] gx_r [3];
  logic signed [pemr_pkg::GRAD_W-1:0] gy_r [3];
  logic [pemr_pkg::SQ_W-1:0] x_r [3];
  logic [pemr_pkg::REM_W-1:0] rem_r [3];
  logic [pemr_pkg::ROOT_W-1:0] root_r [3];
  logic [pemr_pkg::REM_W-1:0] rem_sh [3];
  logic [pemr_pkg::REM_W-1:0] trial [3];
  logic [20:0] prod [3];
  logic [9:0] quo [3];
  logic [7:0] edge_val [3];
  logic out_v_r;
  logic [pemr_pkg::PIX_W-1:0] out_d_r;
  logic out_l_r;

  pemr_ram #(
    .WIDTH(pemr_pkg::PIX_W),
    .DEPTH(pemr_pkg::RAM_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.wr_addr),
    .wdata(pix_data),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem_r[k][pemr_pkg::REM_W-3:0], x_r[k][pemr_pkg::SQ_W-1 -: 2]};
      trial[k]  = pemr_pkg::REM_W'({root_r[k], 2'b01});
      prod[k]   = 21'(root_r[k]) * 21'(pemr_pkg::DIV3_MUL);
      quo[k]    = prod[k][20:pemr_pkg::DIV3_SHIFT];
      edge_val[k] = (quo[k] > 10'(pemr_pkg::PIX_MAX)) ? 8'(pemr_pkg::PIX_MAX) : quo[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    crow_r <= cmd.cell_row;
    ccol_r <= cmd.cell_col;
    for (int k = 0; k < 3; k++) begin
      if (cmd.clr) begin
        gx_r[k] <= '0;
        gy_r[k] <= '0;
      end else if (rd_v_r) begin
        if (ccol_r == 2'd2) begin
          gx_r[k] <= gx_r[k] + $signed({3'b000, rd_data[8*k +: 8]});
        end else if (ccol_r == 2'd0) begin
          gx_r[k] <= gx_r[k] - $signed({3'b000, rd_data[8*k +: 8]});
        end
        if (crow_r == 2'd2) begin
          gy_r[k] <= gy_r[k] + $signed({3'b000, rd_data[8*k +: 8]});
        end else if (crow_r == 2'd0) begin
          gy_r[k] <= gy_r[k] - $signed({3'b000, rd_data[8*k +: 8]});
        end
      end
      if (cmd.sq) begin
        x_r[k]    <= $unsigned(pemr_pkg::SQ_W'(gx_r[k]) * pemr_pkg::SQ_W'(gx_r[k])) +
                     $unsigned(pemr_pkg::SQ_W'(gy_r[k]) * pemr_pkg::SQ_W'(gy_r[k]));
        rem_r[k]  <= '0;
        root_r[k] <= '0;
      end else if (cmd.root_step) begin
        x_r[k] <= {x_r[k][pemr_pkg::SQ_W-3:0], 2'b00};
        if (rem_sh[k] >= trial[k]) begin
          rem_r[k]  <= rem_sh[k] - trial[k];
          root_r[k] <= {root_r[k][pemr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh[k];
          root_r[k] <= {root_r[k][pemr_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.load) begin
      out_d_r <= {edge_val[2], edge_val[1], edge_val[0]};
      out_l_r <= cmd.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (cmd.load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_v_r;
  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tlast    = out_l_r;
endmodule

// ----- rtl/prewitt_edge_magnitude_rgb_core.sv -----
// Top level: 3x3 Prewitt RGB edge magnitude over a raster pixel stream
// Sequence: an item that yields a result goes through 9 RAM reads, an accumulate, a square,
//   11 square-root steps and a scale, and is held back while the output is stalled.
// Flow: a new item waits until the previous result is loaded (serial window read through
//   the one RAM read port, bit-serial root); an item without a result holds nothing up.
// Reset: synchronous active-low; width 640, height 480, positions zero, output empty.
//   Row RAM is not cleared; only cells written in the current frame are read.
module prewitt_edge_magnitude_rgb_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // red_in, green_in, blue_in
  input  logic                       in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // red_edge, green_edge, blue_edge
  output logic                       out_tlast,  // frame_end
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [pemr_pkg::CFG_W-1:0] cfg_wdata
);
  pemr_pkg::cmd_t cmd;
  pemr_pkg::sts_t sts;

  pemr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tuser (in_tuser),
    .in_tready(in_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sts      (sts),
    .cmd      (cmd)
  );

  pemr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .pix_data  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Prewitt RGB edge magnitude core
`timescale 1ns / 100ps

module testbench;
  typedef struct packed {
    logic       kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_item_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = pemr_pkg::CFG_IMAGE_WIDTH;
  logic [pemr_pkg::CFG_W-1:0] cfg_wdata = '0;

  prewitt_edge_magnitude_rgb_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_item_t pending_items[$];
  edge_result_t expected_edges[$];
  int sender_idle_pct = 36;
  int receiver_idle_pct = 67;
  int error_count = 0;
  int cycle_count = 0;
  bit running = 1'b0;

  // predictor state
  logic [23:0] row_ring[4][pemr_pkg::MAX_WIDTH];
  int reg_width = 640, reg_height = 480;
  int in_col, in_row, out_col, out_row;

  function automatic int clamp_size(int v, int m);
    if (v < 1) return 1;
    if (v > m) return m;
    return v;
  endfunction

  function automatic int int_sqrt(int unsigned x);
    int unsigned r = 0;
    for (int k = 31; k >= 0; k--)
      if ((r + (1 << k)) * (r + (1 << k)) <= x && (r + (1 << k)) < 65536) r += (1 << k);
    return r;
  endfunction

  function automatic edge_result_t compute_edge(int w, int h);
    edge_result_t res;
    int rs[3], cs[3];
    int gx, gy, mag;
    rs[0] = (out_row == 0) ? 0 : out_row - 1;
    rs[1] = out_row;
    rs[2] = (out_row + 1 >= h) ? h - 1 : out_row + 1;
    cs[0] = (out_col == 0) ? 0 : out_col - 1;
    cs[1] = out_col;
    cs[2] = (out_col + 1 >= w) ? w - 1 : out_col + 1;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        gx += int'(row_ring[rs[i] % 4][cs[2]][8*ch +: 8])
            - int'(row_ring[rs[i] % 4][cs[0]][8*ch +: 8]);
        gy += int'(row_ring[rs[2] % 4][cs[i]][8*ch +: 8])
            - int'(row_ring[rs[0] % 4][cs[i]][8*ch +: 8]);
      end
      mag = int_sqrt(gx * gx + gy * gy) / 3;
      if (mag > pemr_pkg::PIX_MAX) mag = pemr_pkg::PIX_MAX;
      case (ch)
        0: res.red = mag[7:0];
        1: res.green = mag[7:0];
        default: res.blue = mag[7:0];
      endcase
    end
    res.frame_end = (out_row == h - 1 && out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return res;
  endfunction

  function automatic void predict_edges(pixel_item_t it);
    int w = clamp_size(reg_width, pemr_pkg::MAX_WIDTH);
    int h = clamp_size(reg_height, pemr_pkg::MAX_HEIGHT);
    bit ready;
    if (it.kind == pemr_pkg::KIND_DRAIN) begin
      if (in_row >= h && out_row < h) expected_edges.push_back(compute_edge(w, h));
      return;
    end
    if (in_row >= h || in_col >= w || out_row >= h || out_col >= w) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    row_ring[in_row % 4][in_col] = {it.blue, it.green, it.red};
    ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (ready) expected_edges.push_back(compute_edge(w, h));
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_tvalid && in_tready) predict_edges(pixel_item_t'({in_tuser, in_tdata}));
    if (running && (!in_tvalid || in_tready)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        pixel_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.kind;
        in_tdata <= {it.blue, it.green, it.red};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      edge_result_t got, want;
      got = {out_tlast, out_tdata};
      if (expected_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = expected_edges.pop_front();
        if (got.red != want.red)
          report_mismatch($sformatf("red %0d want %0d", got.red, want.red));
        if (got.green != want.green)
          report_mismatch($sformatf("green %0d want %0d", got.green, want.green));
        if (got.blue != want.blue)
          report_mismatch($sformatf("blue %0d want %0d", got.blue, want.blue));
        if (got.frame_end != want.frame_end)
          report_mismatch($sformatf("frame_end %0b want %0b", got.frame_end, want.frame_end));
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic pixel_item_t rand_pixel();
    pixel_item_t it;
    it.kind = pemr_pkg::KIND_PIXEL;
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    return it;
  endfunction

  function automatic pixel_item_t drain_item();
    pixel_item_t it = rand_pixel();
    it.kind = pemr_pkg::KIND_DRAIN;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [0:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[pemr_pkg::CFG_W-1:0];
    if (idx == pemr_pkg::CFG_IMAGE_WIDTH) reg_width = value & 'h7FF;
    else reg_height = value & 'h7FF;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // full frame with occasional drains mixed in and w+1 to w+3 drains after it; pixels random or extreme
  task automatic queue_frame(int w, int h, bit extreme);
    int n = w * h;
    for (int i = 0; i < n; i++) begin
      pixel_item_t it = rand_pixel();
      if (extreme) begin
        it.red = (i % 2) ? 8'hFF : 8'h00;
        it.green = ((i / w) % 2) ? 8'h00 : 8'hFF;
        it.blue = (i % 3) ? 8'hFF : 8'h00;
      end
      if ($urandom_range(19) == 0) pending_items.push_back(drain_item());
      pending_items.push_back(it);
    end
    for (int i = 0; i < w + 1 + $urandom_range(2); i++) pending_items.push_back(drain_item());
  endtask

  task automatic run_phase(int w, int h, int frames);
    write_size(pemr_pkg::CFG_IMAGE_WIDTH, w);
    write_size(pemr_pkg::CFG_IMAGE_HEIGHT, h);
    running = 1'b1;
    for (int f = 0; f < frames; f++) queue_frame(clamp_size(w, pemr_pkg::MAX_WIDTH),
        clamp_size(h, pemr_pkg::MAX_HEIGHT), f == 0 && $urandom_range(1));
    wait_idle();
  endtask

  // start of an oversized frame, left unfinished
  task automatic run_partial(int w, int h, int n);
    write_size(pemr_pkg::CFG_IMAGE_WIDTH, w);
    write_size(pemr_pkg::CFG_IMAGE_HEIGHT, h);
    running = 1'b1;
    for (int i = 0; i < n; i++) pending_items.push_back(rand_pixel());
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: drain before any pixel, extremes, tiny frames
    pending_items.push_back(drain_item());
    running = 1'b1;
    wait_idle();
    run_phase(3, 3, 1);
    run_phase(1, 1, 2);
    run_phase(1, 4, 1);
    run_phase(4, 1, 1);
    run_phase(0, 0, 1);
    run_partial(2047, 3, 24);
    run_partial(1, 2047, 40);
    // full frame drained only partly, then restart by a new frame that is drained fully
    write_size(pemr_pkg::CFG_IMAGE_WIDTH, 5);
    write_size(pemr_pkg::CFG_IMAGE_HEIGHT, 3);
    running = 1'b1;
    for (int i = 0; i < 15; i++) pending_items.push_back(rand_pixel());
    for (int i = 0; i < 2; i++) pending_items.push_back(drain_item());
    for (int i = 0; i < 15; i++) pending_items.push_back(rand_pixel());
    for (int i = 0; i < 6; i++) pending_items.push_back(drain_item());
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 36 : (p == 1) ? 67 : 0;
      receiver_idle_pct = (p == 0) ? 67 : (p == 1) ? 36 : 0;
      for (int k = 0; k < 3; k++)
        run_phase($urandom_range(2, 8), $urandom_range(2, 7), 1 + $urandom_range(1));
    end
    while (expected_edges.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
